// File: design/dlt_pkg.sv
// Shared widths, request and status codes and memory control type for the list table.
package dlt_pkg;

  // Default geometry
  localparam int ELEM_BITS_DEF = 32;
  localparam int DEPTH_DEF     = 16;

  // Fixed field widths of the channels
  localparam int MODE_W = 3;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 4;
  localparam int ST_W   = 2;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_FIND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADDU = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RMV  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RMI  = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: design/dlt_if.sv
// Request and response channel interfaces of the list table.
interface dlt_req_if import dlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  index;

  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface

interface dlt_rsp_if import dlt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] count;

  modport source (output valid, status, position, count, input ready);
  modport sink   (input valid, status, position, count, output ready);
endinterface

// File: design/dlt_mem.sv
// Entry storage: one write port, one read port with registered read data.
module dlt_mem import dlt_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int DEPTH     = DEPTH_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  mem_ctl_t             ctl_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [ELEM_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [ELEM_BITS-1:0] rdata_o
);

  logic [ELEM_BITS-1:0] mem_q [DEPTH];
  logic [ELEM_BITS-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dlt_ctrl.sv
// Request sequencer: linear search, append and shift-down over the entry memory.
module dlt_ctrl import dlt_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int DEPTH     = DEPTH_DEF,
  localparam int AW       = $clog2(DEPTH),
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dlt_req_if.sink              req_i,
  dlt_rsp_if.source            rsp_o,
  output mem_ctl_t             mem_ctl_o,
  output logic [AW-1:0]        mem_waddr_o,
  output logic [ELEM_BITS-1:0] mem_wdata_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [ELEM_BITS-1:0] mem_rdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam int XW = CW + IDX_W;

  // Control state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic          ov_q, ov_d;

  // Working and result payload
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [ELEM_BITS-1:0] val_q, val_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        paddr_q, paddr_d;
  logic [AW-1:0]        base_q, base_d;
  logic [ST_W-1:0]      rst_q, rst_d;
  logic [AW-1:0]        rpos_q, rpos_d;
  logic [ST_W-1:0]      ost_q, ost_d;
  logic [AW-1:0]        opos_q, opos_d;
  logic [CW-1:0]        ocnt_q, ocnt_d;

  logic full;
  logic hit;
  logic accept;

  assign full   = (cnt_q == CW'(DEPTH));
  assign hit    = pend_q && (mem_rdata_i == val_q);
  assign accept = req_i.valid && req_i.ready;

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = ov_q;
  assign rsp_o.status   = ost_q;
  assign rsp_o.position = POS_W'(opos_q);
  assign rsp_o.count    = CNT_W'(ocnt_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    ov_d        = ov_q;
    mode_d      = mode_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    paddr_d     = paddr_q;
    base_d      = base_q;
    rst_d       = rst_q;
    rpos_d      = rpos_q;
    ost_d       = ost_q;
    opos_d      = opos_q;
    ocnt_d      = ocnt_q;
    mem_ctl_o   = '0;
    mem_waddr_o = cnt_q[AW-1:0];
    mem_wdata_o = val_q;
    mem_raddr_o = ptr_q[AW-1:0];

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = req_i.mode;
          val_d  = ELEM_BITS'(req_i.value);
          ptr_d  = '0;
          pend_d = 1'b0;
          rst_d  = ST_ABSENT;
          rpos_d = '0;
          case (req_i.mode)
            MODE_ADD: begin
              state_d = S_RESP;
              if (full) begin
                rst_d = ST_FULL;
              end else begin
                mem_ctl_o.we = 1'b1;
                mem_wdata_o  = ELEM_BITS'(req_i.value);
                rst_d        = ST_DONE;
                rpos_d       = cnt_q[AW-1:0];
                cnt_d        = cnt_q + CW'(1);
              end
            end
            MODE_FIND, MODE_ADDU, MODE_RMV: begin
              state_d = S_SRCH;
            end
            MODE_RMI: begin
              if (XW'(req_i.index) < XW'(cnt_q)) begin
                base_d  = AW'(req_i.index);
                ptr_d   = CW'(req_i.index) + CW'(1);
                state_d = S_SHIFT;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (hit) begin
          pend_d = 1'b0;
          case (mode_q)
            MODE_FIND: begin
              rst_d   = ST_DONE;
              rpos_d  = paddr_q;
              state_d = S_RESP;
            end
            MODE_ADDU: begin
              rst_d   = ST_DUP;
              state_d = S_RESP;
            end
            MODE_RMV: begin
              base_d  = paddr_q;
              ptr_d   = CW'(paddr_q) + CW'(1);
              state_d = S_SHIFT;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end else if (!pend_q && (ptr_q >= cnt_q)) begin
          // Search ran off the end of the list
          state_d = S_RESP;
          if (mode_q == MODE_ADDU) begin
            if (full) begin
              rst_d = ST_FULL;
            end else begin
              mem_ctl_o.we = 1'b1;
              rst_d        = ST_DONE;
              rpos_d       = cnt_q[AW-1:0];
              cnt_d        = cnt_q + CW'(1);
            end
          end
        end else if (ptr_q < cnt_q) begin
          mem_ctl_o.re = 1'b1;
          pend_d       = 1'b1;
          paddr_d      = ptr_q[AW-1:0];
          ptr_d        = ptr_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one place lower
        if (pend_q) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = paddr_q - AW'(1);
          mem_wdata_o  = mem_rdata_i;
        end
        if (ptr_q < cnt_q) begin
          mem_ctl_o.re = 1'b1;
          pend_d       = 1'b1;
          paddr_d      = ptr_q[AW-1:0];
          ptr_d        = ptr_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            cnt_d   = cnt_q - CW'(1);
            rst_d   = ST_DONE;
            rpos_d  = base_q;
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          ost_d   = rst_q;
          opos_d  = rpos_q;
          ocnt_d  = cnt_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    val_q   <= val_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    base_q  <= base_d;
    rst_q   <= rst_d;
    rpos_q  <= rpos_d;
    ost_q   <= ost_d;
    opos_q  <= opos_d;
    ocnt_q  <= ocnt_d;
  end

endmodule

// File: design/dedup_list_table_core.sv
// Top level of the list table: sequencer and entry memory.
// Add writes the entry on acceptance; find, add unique and remove value search the list,
// a linear search through the single read port, one entry per cycle.
// A removal then shifts later entries down one place, as does remove at index. One item
// at a time; the next is accepted once the result sits in the output register. Reset
// clears count and output valid.
module dedup_list_table_core import dlt_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int DEPTH     = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlt_req_if.sink   req_i,
  dlt_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);

  mem_ctl_t             mem_ctl;
  logic [AW-1:0]        mem_waddr;
  logic [ELEM_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [ELEM_BITS-1:0] mem_rdata;

  dlt_ctrl #(
    .ELEM_BITS (ELEM_BITS),
    .DEPTH     (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dlt_mem #(
    .ELEM_BITS (ELEM_BITS),
    .DEPTH     (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: design/dlt_checker.sv
// Port-level assertions for the list table and their bind to the top level.
module dlt_checker import dlt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [ST_W-1:0]  rsp_status_i,
  input logic [POS_W-1:0] rsp_position_i,
  input logic [CNT_W-1:0] rsp_count_i
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] outst_q;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // Items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_q + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_position_i) && $stable(rsp_count_i))
    else $error("stalled result changed");

  // No result without an item behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> outst_q != 2'd0)
    else $error("result without an item");

  // A new item only while at most one earlier result is still undelivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> outst_q <= 2'd1)
    else $error("item taken while another is in work");

  // Failed requests report position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_DONE |-> rsp_position_i == '0)
    else $error("nonzero position on failure");

  // Full is only reported with a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_count_i == CNT_W'(DEPTH))
    else $error("full reported below depth");

endmodule

bind dedup_list_table_core dlt_checker #(
  .DEPTH (DEPTH)
) u_dlt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_position_i (rsp_o.position),
  .rsp_count_i    (rsp_o.count)
);

// File: dv/dlt_list_checker.sv
// Checker for the list table: predicts the result of every accepted request and compares it.
module dlt_list_checker import dlt_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int DEPTH     = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dlt_req_if               req_i,
  dlt_rsp_if               rsp_i,
  output int               err_cnt_o,
  output int               pend_cnt_o,
  output logic [3:0][15:0] status_tally_o
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } outcome_t;

  // Only the low ELEM_BITS bits of a value take part
  localparam logic [VAL_W-1:0] ELEM_MASK =
    (ELEM_BITS >= VAL_W) ? '1 : VAL_W'((64'd1 << ELEM_BITS) - 64'd1);

  // Shadow copy of the list and the results still owed by the block
  logic [VAL_W-1:0] held [DEPTH];
  int               held_cnt;
  outcome_t         outcome_q [$];
  outcome_t         seen;
  outcome_t         want;

  // First position holding v, DEPTH when absent
  function automatic int locate(logic [VAL_W-1:0] v);
    for (int i = 0; i < held_cnt; i++) begin
      if (held[i] == v) return i;
    end
    return DEPTH;
  endfunction

  // Delete one entry and close the gap
  function automatic void drop_at(int p);
    for (int i = p; i + 1 < held_cnt; i++) held[i] = held[i + 1];
    held_cnt--;
  endfunction

  // Apply one request to the shadow list and return the result it should give
  function automatic outcome_t list_apply(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] raw,
                                          logic [IDX_W-1:0] idx);
    outcome_t         o;
    int               p;
    logic [VAL_W-1:0] v;
    v          = raw & ELEM_MASK;
    o.status   = ST_ABSENT;
    o.position = '0;
    case (mode)
      MODE_FIND: begin
        p = locate(v);
        if (p < DEPTH) begin
          o.status   = ST_DONE;
          o.position = POS_W'(p);
        end
      end
      MODE_ADD, MODE_ADDU: begin
        // duplicate check wins over the full check
        if (mode == MODE_ADDU && locate(v) < DEPTH) begin
          o.status = ST_DUP;
        end else if (held_cnt >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          held[held_cnt] = v;
          o.position     = POS_W'(held_cnt);
          o.status       = ST_DONE;
          held_cnt++;
        end
      end
      MODE_RMV: begin
        p = locate(v);
        if (p < DEPTH) begin
          drop_at(p);
          o.status   = ST_DONE;
          o.position = POS_W'(p);
        end
      end
      MODE_RMI: begin
        if (int'(idx) < held_cnt) begin
          drop_at(int'(idx));
          o.status   = ST_DONE;
          o.position = idx;
        end
      end
      default: ;
    endcase
    o.count = CNT_W'(held_cnt);
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $time, what);
    err_cnt_o++;
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 0;
      outcome_q.delete();
      pend_cnt_o     = 0;
      err_cnt_o      = 0;
      status_tally_o = '0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        outcome_q.push_back(list_apply(req_i.mode, req_i.value, req_i.index));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        seen.status   = rsp_i.status;
        seen.position = rsp_i.position;
        seen.count    = rsp_i.count;
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: %0d %0d %0d",
                                    seen.status, seen.position, seen.count));
        end else begin
          want = outcome_q.pop_front();
          status_tally_o[want.status]++;
          if (seen.status !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d", want.status, seen.status));
          if (seen.position !== want.position)
            report_mismatch($sformatf("position: expected %0d, got %0d",
                                      want.position, seen.position));
          if (seen.count !== want.count)
            report_mismatch($sformatf("count: expected %0d, got %0d", want.count, seen.count));
        end
      end
      pend_cnt_o = outcome_q.size();
    end
  end

endmodule

// File: dv/dedup_list_table_core_tb.sv
// Testbench top for the list table: clock, reset, request stimulus, output stalls and verdict.
module dedup_list_table_core_tb;
  import dlt_pkg::*;

  localparam int HOLD_LEN     = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int N_RANDOM     = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 38;
  localparam int PHASE_LEN    = 40;
  localparam int POOL_SIZE    = 8;

  // Mode codes the block does not define
  localparam logic [MODE_W-1:0] MODE_RSVD_LO = MODE_RMI + 1'b1;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dlt_req_if req_ch ();
  dlt_rsp_if rsp_ch ();

  int               err_cnt;
  int               pend_cnt;
  logic [3:0][15:0] status_tally;

  bit               tx_steady;
  bit               rx_steady;
  bit               rx_hold_req;
  int               n_sent;
  int               n_directed;
  logic [VAL_W-1:0] pool [POOL_SIZE];

  dedup_list_table_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  dlt_list_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_i          (req_ch),
    .rsp_i          (rsp_ch),
    .err_cnt_o      (err_cnt),
    .pend_cnt_o     (pend_cnt),
    .status_tally_o (status_tally)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request, with an optional random gap first, and wait for acceptance
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] v,
                              input logic [IDX_W-1:0] idx);
    if (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.value <= v;
    req_ch.index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
  endtask

  // Result side: random stalls, steady stretches and one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rx_steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pend_cnt);
    $display("dedup_list_table_core regression: fail");
    $finish;
  end

  // Request stimulus
  initial begin
    int               r;
    bit               grow;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0] v;
    logic [IDX_W-1:0] idx;

    req_ch.valid <= 1'b0;
    req_ch.mode  <= MODE_FIND;
    req_ch.value <= '0;
    req_ch.index <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: nothing to find or remove, undefined mode
    send_request(MODE_FIND, '1, '0);
    send_request(MODE_RMV, '0, '0);
    send_request(MODE_RMI, '0, '0);
    send_request(MODE_RSVD_HI, '1, '1);
    // Extremes, plain add of a repeat, refused repeat, first match wins
    send_request(MODE_ADD, '0, '1);
    send_request(MODE_ADD, '1, '0);
    send_request(MODE_ADD, '0, '0);
    send_request(MODE_ADDU, '1, '0);
    send_request(MODE_FIND, '0, '1);
    send_request(MODE_RMV, '0, '0);
    // Fill up, then add to a full list, repeat on a full list, trim the tail
    for (int k = 0; k < 14; k++) send_request(MODE_ADD, VAL_W'(32'h8000_0001) << k, '0);
    send_request(MODE_ADD, 32'h5a5a_a5a5, '0);
    send_request(MODE_ADDU, '1, '0);
    send_request(MODE_RMI, '0, '1);
    send_request(MODE_RMI, '0, '1);
    n_directed = n_sent;

    // Random part: alternate growing and shrinking phases over a small value pool
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        foreach (pool[i]) pool[i] = $urandom;
      end
      tx_steady = (n >= 120 && n < 220) || (n >= 300 && n < 316);
      rx_steady = (n >= 120 && n < 220);
      if (n == 260) begin
        // let every outstanding result come back before going on
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pend_cnt != 0);
      end
      if (n == 300) rx_hold_req = 1'b1;

      grow = ((n / PHASE_LEN) % 2) == 0;
      r    = $urandom_range(0, 99);
      if (r >= 96)                  mode = MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
      else if (r < (grow ? 10 : 15)) mode = MODE_FIND;
      else if (r < (grow ? 45 : 25)) mode = MODE_ADD;
      else if (r < (grow ? 70 : 35)) mode = MODE_ADDU;
      else if (r < (grow ? 82 : 65)) mode = MODE_RMV;
      else                          mode = MODE_RMI;
      v   = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                                        : pool[$urandom_range(0, POOL_SIZE - 1)];
      idx = ($urandom_range(0, 9) < 6) ? IDX_W'($urandom_range(0, 3))
                                       : IDX_W'($urandom_range(0, 15));
      send_request(mode, v, idx);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (pend_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d directed, through a full list and back): %0d done, %0d %s",
             n_sent, n_directed, status_tally[ST_DONE], status_tally[ST_ABSENT],
             "absent or out of range,");
    $display("%0d duplicates refused, %0d full; random stalls, a %0d-cycle hold-off, a drain pause.",
             status_tally[ST_DUP], status_tally[ST_FULL], HOLD_LEN);
    if (err_cnt == 0) begin
      $display("dedup_list_table_core regression: pass");
    end else begin
      $display("dedup_list_table_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/dlt_pkg.sv
design/dlt_if.sv
design/dlt_mem.sv
design/dlt_ctrl.sv
design/dedup_list_table_core.sv
design/dlt_checker.sv
dv/dlt_list_checker.sv
dv/dedup_list_table_core_tb.sv
